>>> hw/rtl/cpesc_pkg.sv
// Shared types, ASCII constants and byte-forming functions for the code point escape encoder.
// No dependencies; imported by cpesc_emit and codepoint_escape_encoder_top.
`timescale 1ns / 1ps

package cpesc_pkg;

	localparam int unsigned CP_W   = 32;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned IDX_W  = 4;   // byte index within a run, up to ten bytes

	// ASCII characters used by the escapes
	localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [BYTE_W-1:0] CH_N      = 8'h6E;
	localparam logic [BYTE_W-1:0] CH_R      = 8'h72;
	localparam logic [BYTE_W-1:0] CH_T      = 8'h74;
	localparam logic [BYTE_W-1:0] CH_X      = 8'h78;
	localparam logic [BYTE_W-1:0] CH_LU     = 8'h75;
	localparam logic [BYTE_W-1:0] CH_UU     = 8'h55;
	localparam logic [BYTE_W-1:0] HEX_LETTER_BASE = 8'h57;  // 'a' - 10

	// control characters with a short escape
	localparam logic [CP_W-1:0] CP_NUL    = 32'h0000_0000;
	localparam logic [CP_W-1:0] CP_TAB    = 32'h0000_0009;
	localparam logic [CP_W-1:0] CP_LF     = 32'h0000_000A;
	localparam logic [CP_W-1:0] CP_CR     = 32'h0000_000D;
	localparam logic [CP_W-1:0] CP_SPACE  = 32'h0000_0020;
	localparam logic [CP_W-1:0] CP_QUOTE  = 32'h0000_0022;
	localparam logic [CP_W-1:0] CP_BSLASH = 32'h0000_005C;
	localparam logic [CP_W-1:0] CP_DEL    = 32'h0000_007F;
	localparam logic [CP_W-1:0] CP_HEX2_LIMIT = 32'h0000_0100;
	localparam logic [CP_W-1:0] CP_HEX4_LIMIT = 32'h0001_0000;

	typedef enum logic [2:0] {
		KIND_PLAIN,
		KIND_SHORT,
		KIND_HEX2,
		KIND_HEX4,
		KIND_HEX8
	} kind_t;

	// one classified code point handed to the byte emitter
	typedef struct packed {
		logic [CP_W-1:0]   cp;
		kind_t             kind;
		logic [BYTE_W-1:0] sym;   // plain byte, or the letter after the backslash
	} item_t;

	function automatic kind_t classify(input logic [CP_W-1:0] cp);
		kind_t k;
		if (cp == CP_LF || cp == CP_CR || cp == CP_TAB || cp == CP_NUL ||
		    cp == CP_QUOTE || cp == CP_BSLASH || cp == CP_SPACE) begin
			k = KIND_SHORT;
		end else if (cp >= CP_SPACE && cp < CP_DEL) begin
			k = KIND_PLAIN;
		end else if (cp < CP_HEX2_LIMIT) begin
			k = KIND_HEX2;
		end else if (cp < CP_HEX4_LIMIT) begin
			k = KIND_HEX4;
		end else begin
			k = KIND_HEX8;
		end
		return k;
	endfunction

	function automatic logic [BYTE_W-1:0] symbol(input logic [CP_W-1:0] cp, input kind_t k);
		logic [BYTE_W-1:0] s;
		unique case (k)
			KIND_PLAIN: s = cp[BYTE_W-1:0];
			KIND_SHORT: begin
				case (cp[BYTE_W-1:0])
					CP_LF[BYTE_W-1:0]:  s = CH_N;
					CP_CR[BYTE_W-1:0]:  s = CH_R;
					CP_TAB[BYTE_W-1:0]: s = CH_T;
					CP_NUL[BYTE_W-1:0]: s = CH_ZERO;
					default:            s = cp[BYTE_W-1:0];  // quote, backslash, space
				endcase
			end
			KIND_HEX2: s = CH_X;
			KIND_HEX4: s = CH_LU;
			KIND_HEX8: s = CH_UU;
			default:   s = cp[BYTE_W-1:0];
		endcase
		return s;
	endfunction

	// total bytes in the run for a kind
	function automatic logic [IDX_W-1:0] run_len(input kind_t k);
		logic [IDX_W-1:0] n;
		unique case (k)
			KIND_PLAIN: n = 4'd1;
			KIND_SHORT: n = 4'd2;
			KIND_HEX2:  n = 4'd4;
			KIND_HEX4:  n = 4'd6;
			KIND_HEX8:  n = 4'd10;
			default:    n = 4'd1;
		endcase
		return n;
	endfunction

	function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
		logic [BYTE_W-1:0] c;
		if (nib < 4'd10) begin
			c = CH_ZERO + {4'd0, nib};
		end else begin
			c = HEX_LETTER_BASE + {4'd0, nib};
		end
		return c;
	endfunction

	// byte at position idx of the run for one item
	function automatic logic [BYTE_W-1:0] byte_at(input item_t it, input logic [IDX_W-1:0] idx);
		logic [BYTE_W-1:0] b;
		logic [IDX_W-1:0]  digits;
		logic [IDX_W-1:0]  nib_pos;
		logic [CP_W-1:0]   shifted;
		digits  = run_len(it.kind) - 4'd2;
		nib_pos = digits + 4'd1 - idx;  // most significant digit first
		shifted = it.cp >> {nib_pos[2:0], 2'b00};
		if (idx == 4'd0) begin
			b = (it.kind == KIND_PLAIN) ? it.sym : CH_BSLASH;
		end else if (idx == 4'd1) begin
			b = it.sym;
		end else begin
			b = hex_char(shifted[3:0]);
		end
		return b;
	endfunction

endpackage

>>> hw/rtl/cpesc_emit.sv
// Byte emitter: walks one classified code point through its escape run, one byte a cycle.
// Depends on cpesc_pkg for item_t, run_len and byte_at.
`timescale 1ns / 1ps

module cpesc_emit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	input  cpesc_pkg::item_t                item,
	output logic                            take,
	output logic                            valid,
	output logic [cpesc_pkg::BYTE_W-1:0]    out_byte,
	output logic                            last_byte
);
	import cpesc_pkg::*;

	logic             active_q;
	item_t            item_q;
	logic [IDX_W-1:0] idx_q;
	logic             done_now;
	logic [BYTE_W-1:0] cur_byte;

	logic              valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              last_q;

	// current byte and end of run
	always_comb begin
		done_now = active_q && (idx_q == run_len(item_q.kind) - 4'd1);
		cur_byte = byte_at(item_q, idx_q);
		take     = item_valid && (!active_q || done_now);
	end

	// load a new request or advance through the run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (take) begin
			active_q <= 1'b1;
			idx_q    <= '0;
		end else if (done_now) begin
			active_q <= 1'b0;
		end else if (active_q) begin
			idx_q <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_q <= item;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		out_byte_q <= cur_byte;
		last_q     <= done_now;
	end

	assign valid     = valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = last_q && valid_q;

`ifndef SYNTHESIS
	// index never runs past the end of its run
	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> idx_q < run_len(item_q.kind))
		else $error("emitter index past end of run");

	// mid-run the emitter keeps going with the next byte
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && !done_now) |=> (active_q && idx_q == $past(idx_q) + 4'd1))
		else $error("emitter dropped a run before its last byte");

	// a new request is only taken when the emitter is free or finishing
	a_take_free: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && !done_now) |-> !take)
		else $error("request taken while a run is in progress");

	// a byte whose successor belongs to a new run must be marked last
	a_last_before_new: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (valid && last_byte) || !$past(active_q))
		else $error("run ended without a last marker");
`endif

endmodule

>>> hw/rtl/codepoint_escape_encoder_top.sv
// Top level of the code point escape encoder: input register, classification, byte emitter.
// Depends on cpesc_pkg and cpesc_emit.
`timescale 1ns / 1ps

// Channel   | Handshake          | Payload
// ----------+--------------------+---------------------------
// request   | start / busy       | code_point[31:0]
// result    | valid (strobe)     | out_byte[7:0], last_byte
//
// One byte leaves per cycle while a run is in progress; a request occupies the emitter for its run,
// whose length in bytes is 1 plain, 2 short escape, 4 for \x, 6 for \u, 10 for \U.
// The first byte passes the input register, the emitter's run state and its result register; a busy emitter delays it.
// Reset clears all valid and run state; no clearing pass.
// The receiver cannot stall; busy rises only while the emitter is inside a longer run.
module codepoint_escape_encoder_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [cpesc_pkg::CP_W-1:0]    code_point,
	output logic                          valid,
	output logic [cpesc_pkg::BYTE_W-1:0]  out_byte,
	output logic                          last_byte
);
	import cpesc_pkg::*;

	logic            vld_s1;
	logic [CP_W-1:0] cp_s1;
	logic            take;
	item_t           item;
	kind_t           kind;

	// hold off new requests while the registered one waits
	assign busy = vld_s1 && !take;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!busy) begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cp_s1 <= code_point;
		end
	end

	// classify the registered code point
	always_comb begin
		kind      = classify(cp_s1);
		item.cp   = cp_s1;
		item.kind = kind;
		item.sym  = symbol(cp_s1, kind);
	end

	cpesc_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (vld_s1),
		.item       (item),
		.take       (take),
		.valid      (valid),
		.out_byte   (out_byte),
		.last_byte  (last_byte)
	);

endmodule

>>> tb/tb_codepoint_escape_encoder_top.sv
// Self-checking bench for codepoint_escape_encoder_top: directed and random code points,
// predicted byte runs compared with each strobed output byte. Depends on cpesc_pkg.
`timescale 1ns / 1ps

module tb_codepoint_escape_encoder_top;

	import cpesc_pkg::*;

	localparam int unsigned LETTER_A    = 8'h61;
	localparam int unsigned DRAIN_TICKS = 16;

	typedef struct {
		logic [BYTE_W-1:0] text;
		logic              last;
	} escape_byte_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start = 1'b0;
	logic              busy;
	logic [CP_W-1:0]   code_point = '0;
	logic              valid;
	logic [BYTE_W-1:0] out_byte;
	logic              last_byte;

	logic [CP_W-1:0] pending_points[$];
	escape_byte_t    expected_bytes[$];
	int unsigned     gap_left;
	int unsigned     burst_left = 0;
	int unsigned     mismatches = 0;

	codepoint_escape_encoder_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.code_point (code_point),
		.valid      (valid),
		.out_byte   (out_byte),
		.last_byte  (last_byte)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40) begin
			$display("MISMATCH at %0t: %s", $time, msg);
		end
	endtask

	function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
		return (nib < 4'd10) ? CH_ZERO + BYTE_W'(nib) : BYTE_W'(LETTER_A) + BYTE_W'(nib) - 8'd10;
	endfunction

	// Build the escaped text of one code point and queue it byte by byte
	task automatic queue_escape(input logic [CP_W-1:0] cp);
		logic [BYTE_W-1:0] text[$];
		logic [BYTE_W-1:0] esc;
		logic              is_short;
		int                digits;
		escape_byte_t      eb;
		is_short = 1'b1;
		esc      = '0;
		digits   = 0;
		case (cp)
			CP_LF:   esc = CH_N;
			CP_CR:   esc = CH_R;
			CP_TAB:  esc = CH_T;
			CP_NUL:  esc = CH_ZERO;
			CP_QUOTE, CP_BSLASH, CP_SPACE: esc = cp[BYTE_W-1:0];
			default: is_short = 1'b0;
		endcase
		if (is_short) begin
			text.push_back(CH_BSLASH);
			text.push_back(esc);
		end else if (cp >= CP_SPACE && cp < CP_DEL) begin
			text.push_back(cp[BYTE_W-1:0]);
		end else if (cp < CP_HEX2_LIMIT) begin
			text.push_back(CH_BSLASH);
			text.push_back(CH_X);
			digits = 2;
		end else if (cp < CP_HEX4_LIMIT) begin
			text.push_back(CH_BSLASH);
			text.push_back(CH_LU);
			digits = 4;
		end else begin
			text.push_back(CH_BSLASH);
			text.push_back(CH_UU);
			digits = 8;
		end
		// most significant digit first
		for (int i = digits - 1; i >= 0; i--) begin
			text.push_back(hex_digit(cp[i*4 +: 4]));
		end
		foreach (text[j]) begin
			eb.text = text[j];
			eb.last = (j == text.size() - 1);
			expected_bytes.push_back(eb);
		end
	endtask

	// Mostly back-to-back requests, some short gaps, a few long ones, and bursts with none
	function automatic int unsigned next_gap();
		int unsigned r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 8) begin
			burst_left = $urandom_range(15, 40);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic logic [CP_W-1:0] random_code_point();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 25) return $urandom_range(32, 126);
		if (r < 37) begin
			case ($urandom_range(0, 6))
				0: return CP_NUL;
				1: return CP_TAB;
				2: return CP_LF;
				3: return CP_CR;
				4: return CP_SPACE;
				5: return CP_QUOTE;
				default: return CP_BSLASH;
			endcase
		end
		if (r < 52) return $urandom_range(0, 255);
		if (r < 68) return $urandom_range(256, 65535);
		if (r < 90) return $urandom();
		// class boundaries
		case ($urandom_range(0, 7))
			0: return 32'h0000_001F;
			1: return 32'h0000_007E;
			2: return CP_DEL;
			3: return 32'h0000_00FF;
			4: return CP_HEX2_LIMIT;
			5: return 32'h0000_FFFF;
			6: return CP_HEX4_LIMIT;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	// Present requests from the pending queue; record each one the block takes
	always @(posedge clk or negedge arst_n) begin : driver
		logic        taken;
		int unsigned g;
		if (!arst_n) begin
			start      <= 1'b0;
			code_point <= '0;
			gap_left   <= 0;
		end else begin
			taken = start && !busy;
			if (taken) begin
				queue_escape(code_point);
				void'(pending_points.pop_front());
			end
			// hold a request that was not taken yet
			if (!start || taken) begin
				g = taken ? next_gap() : gap_left;
				if (g == 0 && pending_points.size() != 0) begin
					start      <= 1'b1;
					code_point <= pending_points[0];
					gap_left   <= 0;
				end else begin
					start      <= 1'b0;
					code_point <= $urandom();
					gap_left   <= (g == 0) ? 0 : g - 1;
				end
			end
		end
	end

	// Compare every strobed byte with the oldest expected one
	always @(posedge clk) begin : monitor
		escape_byte_t want;
		if (arst_n && valid) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("byte %h with nothing expected", out_byte));
			end else begin
				want = expected_bytes.pop_front();
				if (out_byte !== want.text) begin
					report_mismatch($sformatf("out_byte %h, want %h", out_byte, want.text));
				end
				if (last_byte !== want.last) begin
					report_mismatch($sformatf("last_byte %b, want %b", last_byte, want.last));
				end
			end
		end
	end

	initial begin
		// every short escape, class edges, and bit extremes
		pending_points = '{
			CP_NUL, CP_TAB, CP_LF, CP_CR, CP_SPACE, CP_QUOTE, CP_BSLASH,
			32'h0000_0021, 32'h0000_0041, 32'h0000_007E, 32'h0000_0001, 32'h0000_001F,
			CP_DEL, 32'h0000_0080, 32'h0000_00FF, CP_HEX2_LIMIT, 32'h0000_ABCD,
			32'h0000_FFFF, CP_HEX4_LIMIT, 32'h0010_FFFF, 32'h0011_0000,
			32'h1234_ABCD, 32'hDEAD_BEEF, 32'h8000_0000, 32'hFFFF_FFFF
		};
		repeat (300) pending_points.push_back(random_code_point());

		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// drain requests, then results, then watch for stray bytes
		while (pending_points.size() != 0 || start) @(posedge clk);
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_TICKS) @(posedge clk);

		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
